### design/euler_rotation_matrix_assert.svh
// assertion macros for the rotation matrix checker
`ifndef EULER_ROTATION_MATRIX_ASSERT_SVH
`define EULER_ROTATION_MATRIX_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define ERM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define ERM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### design/erm_pkg.sv
// types and constants for the rotation matrix block
`timescale 1ns / 1ps
`default_nettype none
package erm_pkg;
  localparam int unsigned TableLen = 24;
  localparam int unsigned Q30W = 34;
  localparam int unsigned MulW = 36;

  typedef struct packed {
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
  } erm_in_t;

  typedef struct packed {
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m13;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic signed [15:0] m23;
    logic signed [15:0] m31;
    logic signed [15:0] m32;
    logic signed [15:0] m33;
  } erm_out_t;

  // per-angle working vector carried down the cordic row
  typedef struct packed {
    logic signed [Q30W-1:0] x;
    logic signed [Q30W-1:0] y;
    logic signed [Q30W-1:0] z;
    logic flip;
  } erm_vec_t;

  localparam logic signed [Q30W-1:0] PiQ30 = 34'sd3373259426;
  localparam logic signed [Q30W-1:0] TwoPiQ30 = 34'sd6746518852;
  localparam logic signed [Q30W-1:0] HalfPiQ30 = 34'sd1686629713;
  localparam logic signed [Q30W-1:0] GainInfQ30 = 34'sd652032874;
  localparam logic [Q30W-1:0] GainCorrQ30 = 34'd434688582;

  function automatic logic signed [Q30W-1:0] atan_q30(input int unsigned i);
    logic signed [Q30W-1:0] r;
    case (i)
      0: r = 34'sd843314856;  1: r = 34'sd497837829;
      2: r = 34'sd263043836;  3: r = 34'sd133525158;
      4: r = 34'sd67021686;   5: r = 34'sd33543515;
      6: r = 34'sd16775850;   7: r = 34'sd8388437;
      8: r = 34'sd4194282;    9: r = 34'sd2097149;
      10: r = 34'sd1048575;   11: r = 34'sd524287;
      12: r = 34'sd262143;    13: r = 34'sd131071;
      14: r = 34'sd65535;     15: r = 34'sd32767;
      16: r = 34'sd16383;     17: r = 34'sd8191;
      18: r = 34'sd4095;      19: r = 34'sd2047;
      20: r = 34'sd1023;      21: r = 34'sd511;
      22: r = 34'sd255;       23: r = 34'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

  // q30 product with round half up
  function automatic logic signed [Q30W-1:0] mul30(input logic signed [Q30W-1:0] a,
                                                   input logic signed [Q30W-1:0] b);
    logic signed [2*Q30W-1:0] p;
    p = a * b + (68'sd1 <<< 29);
    return p[Q30W+29:30];
  endfunction

  // q30 to q2.14 with rounding and saturation
  function automatic logic signed [15:0] to_q14(input logic signed [MulW-1:0] v);
    logic signed [MulW-1:0] r;
    r = (v + 36'sd32768) >>> 16;
    if (r > 36'sd16384) r = 36'sd16384;
    if (r < -36'sd16384) r = -36'sd16384;
    return r[15:0];
  endfunction
endpackage
`default_nettype wire

### design/erm_cordic_cell.sv
// one cordic micro-rotation cell for the three angles
`timescale 1ns / 1ps
`default_nettype none
module erm_cordic_cell #(
  parameter int unsigned Idx = 0
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire logic valid_i,
  input  erm_pkg::erm_vec_t [2:0] vec_i,
  output logic valid_o,
  output erm_pkg::erm_vec_t [2:0] vec_o
);
  import erm_pkg::*;
  erm_vec_t [2:0] vec_d, vec_q;
  logic valid_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vec_d[k] = vec_i[k];
      if (!vec_i[k].z[Q30W-1]) begin
        vec_d[k].x = vec_i[k].x - (vec_i[k].y >>> Idx);
        vec_d[k].y = vec_i[k].y + (vec_i[k].x >>> Idx);
        vec_d[k].z = vec_i[k].z - atan_q30(Idx);
      end else begin
        vec_d[k].x = vec_i[k].x + (vec_i[k].y >>> Idx);
        vec_d[k].y = vec_i[k].y - (vec_i[k].x >>> Idx);
        vec_d[k].z = vec_i[k].z + atan_q30(Idx);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q <= vec_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o = vec_q;
endmodule
`default_nettype wire

### design/erm_matrix.sv
// product pipeline forming the nine matrix entries
`timescale 1ns / 1ps
`default_nettype none
module erm_matrix (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire logic valid_i,
  input  erm_pkg::erm_vec_t [2:0] vec_i,
  output logic valid_o,
  output erm_pkg::erm_out_t res_o
);
  import erm_pkg::*;
  logic signed [Q30W-1:0] sx, cx, sy, cy, sz, cz;
  logic signed [Q30W-1:0] sx_q, cx_q, sy_q, cy_q, sz_q, cz_q;
  logic signed [Q30W-1:0] czsy_q, szsy_q, czcy_q, szcy_q, cysx_q, cycx_q;
  logic signed [Q30W-1:0] szcx_q, szsx_q, czcx_q, czsx_q;
  logic signed [Q30W-1:0] sx2_q, cx2_q;
  logic signed [Q30W-1:0] a1_q, a2_q, a4_q, a5_q;
  logic signed [Q30W-1:0] szcx2_q, szsx2_q, czcx2_q, czsx2_q;
  logic signed [Q30W-1:0] czcy2_q, szcy2_q, cysx2_q, cycx2_q, sy2_q, sy3_q;
  logic [3:0] v_q;
  erm_out_t res_q;

  // undo the half-turn fold
  assign cx = vec_i[0].flip ? -vec_i[0].x : vec_i[0].x;
  assign sx = vec_i[0].flip ? -vec_i[0].y : vec_i[0].y;
  assign cy = vec_i[1].flip ? -vec_i[1].x : vec_i[1].x;
  assign sy = vec_i[1].flip ? -vec_i[1].y : vec_i[1].y;
  assign cz = vec_i[2].flip ? -vec_i[2].x : vec_i[2].x;
  assign sz = vec_i[2].flip ? -vec_i[2].y : vec_i[2].y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_q <= sx; cx_q <= cx; sy_q <= sy; cy_q <= cy; sz_q <= sz; cz_q <= cz;
      czsy_q <= mul30(cz_q, sy_q);
      szsy_q <= mul30(sz_q, sy_q);
      czcy_q <= mul30(cz_q, cy_q);
      szcy_q <= mul30(sz_q, cy_q);
      cysx_q <= mul30(cy_q, sx_q);
      cycx_q <= mul30(cy_q, cx_q);
      szcx_q <= mul30(sz_q, cx_q);
      szsx_q <= mul30(sz_q, sx_q);
      czcx_q <= mul30(cz_q, cx_q);
      czsx_q <= mul30(cz_q, sx_q);
      sx2_q <= sx_q; cx2_q <= cx_q;
      a1_q <= mul30(czsy_q, sx2_q);
      a2_q <= mul30(czsy_q, cx2_q);
      a4_q <= mul30(szsy_q, sx2_q);
      a5_q <= mul30(szsy_q, cx2_q);
      szcx2_q <= szcx_q; szsx2_q <= szsx_q; czcx2_q <= czcx_q; czsx2_q <= czsx_q;
      czcy2_q <= czcy_q; szcy2_q <= szcy_q; cysx2_q <= cysx_q; cycx2_q <= cycx_q;
      sy2_q <= sy_q;
      sy3_q <= sy2_q;
      res_q.m11 <= to_q14(MulW'(czcy2_q));
      res_q.m12 <= to_q14(MulW'(a1_q) - MulW'(szcx2_q));
      res_q.m13 <= to_q14(MulW'(a2_q) + MulW'(szsx2_q));
      res_q.m21 <= to_q14(MulW'(szcy2_q));
      res_q.m22 <= to_q14(MulW'(a4_q) + MulW'(czcx2_q));
      res_q.m23 <= to_q14(MulW'(a5_q) - MulW'(czsx2_q));
      res_q.m31 <= to_q14(-MulW'(sy3_q));
      res_q.m32 <= to_q14(MulW'(cysx2_q));
      res_q.m33 <= to_q14(MulW'(cycx2_q));
    end
  end
  // four stages: operands, two-term products with held sx/cx, three-term
  // products with held pairs, rounded entries
  assign valid_o = v_q[3];
  assign res_o = res_q;
endmodule
`default_nettype wire

### design/euler_rotation_matrix.sv
// top level: euler angles to zyx rotation matrix
// usage:
// - input channel in_valid_i/in_ready_o carries one angle triple per transaction,
//   each angle signed q4.12 radians
// - output channel out_valid_o/out_ready_i carries the nine q2.14 entries
// - one transaction accepted per cycle when the output is not stalled
// - path: a range-reduction register, a row of Stages cordic cells (CORDIC_STAGES
//   capped at TableLen), then the 4 product stages
// - the whole pipeline advances together; a stalled receiver freezes it,
//   and in_ready_o is high whenever the last stage can move on
// - reset clears all valid flags; payload registers are not reset
`timescale 1ns / 1ps
`default_nettype none
module euler_rotation_matrix #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic in_ready_o,
  input  erm_pkg::erm_in_t in_data_i,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output erm_pkg::erm_out_t out_data_o
);
  import erm_pkg::*;
  localparam int unsigned Stages = (CORDIC_STAGES > TableLen) ? TableLen : CORDIC_STAGES;
  localparam logic signed [Q30W-1:0] Gain =
    GainInfQ30 + $signed(GainCorrQ30 >> (2 * Stages));

  logic en;
  logic [Stages:0] cv;
  erm_vec_t [Stages:0][2:0] cvec;
  erm_vec_t [2:0] red_d;
  logic signed [15:0] ang [3];
  logic signed [Q30W-1:0] z0, z1;

  // pipeline moves unless the result register is full and stalled
  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  assign ang[0] = in_data_i.angle_x;
  assign ang[1] = in_data_i.angle_y;
  assign ang[2] = in_data_i.angle_z;

  // range reduction into [-pi/2, pi/2] with a sign flag
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      z0 = Q30W'(ang[k]) <<< 18;
      if (z0 > PiQ30) z0 = z0 - TwoPiQ30;
      else if (z0 < -PiQ30) z0 = z0 + TwoPiQ30;
      z1 = z0;
      red_d[k].flip = 1'b0;
      if (z0 > HalfPiQ30) begin
        z1 = z0 - PiQ30;
        red_d[k].flip = 1'b1;
      end else if (z0 < -HalfPiQ30) begin
        z1 = z0 + PiQ30;
        red_d[k].flip = 1'b1;
      end
      red_d[k].x = Gain;
      red_d[k].y = '0;
      red_d[k].z = z1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv[0] <= 1'b0;
    end else if (en) begin
      cv[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cvec[0] <= red_d;
    end
  end

  // row of cordic cells, one micro-rotation each
  for (genvar g = 0; g < Stages; g++) begin : g_cell
    erm_cordic_cell #(.Idx(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cv[g]),
      .vec_i   (cvec[g]),
      .valid_o (cv[g+1]),
      .vec_o   (cvec[g+1])
    );
  end

  erm_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cv[Stages]),
    .vec_i   (cvec[Stages]),
    .valid_o (out_valid_o),
    .res_o   (out_data_o)
  );
endmodule
`default_nettype wire

### design/euler_rotation_matrix_chk.sv
// port checker for the rotation matrix block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "euler_rotation_matrix_assert.svh"
module euler_rotation_matrix_chk (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input erm_pkg::erm_out_t out_data_o
);
  import erm_pkg::*;
  `ERM_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `ERM_ASSERT_IMP(a_ready, clk_i, rst_ni, !out_valid_o || out_ready_i, in_ready_o)
  `ERM_ASSERT_IMP(a_stall, clk_i, rst_ni, out_valid_o && !out_ready_i, !in_ready_o)
  `ERM_ASSERT_IMP(a_m31, clk_i, rst_ni, out_valid_o, out_data_o.m31 <= 16'sd16384 && out_data_o.m31 >= -16'sd16384)
endmodule
bind euler_rotation_matrix euler_rotation_matrix_chk u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
);
`default_nettype wire
